// ===== design/plddv_pkg.sv =====
// Shared types and constants for the posting-list delta varint decoder.
// No dependencies.
package plddv_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] doc_id;
    logic [1:0]  status;
    logic [31:0] consumed_bytes;
  } out_item_t;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic KIND_ID     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  localparam logic [6:0] SHIFT_STEP = 7'd7;
  localparam logic [6:0] SHIFT_LAST = 7'd63;

endpackage

// ===== design/plddv_in_stage.sv =====
// Input register of the decoder: holds one request until the core takes it.
// Depends on plddv_pkg.
module plddv_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  plddv_pkg::in_item_t in_data,
  input  logic               take,
  output logic               vld,
  output plddv_pkg::in_item_t item
);
  import plddv_pkg::*;

  logic     vld_r;
  in_item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld      = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== design/plddv_core.sv =====
// Decoder state and combinational step: block header, varint shift-or,
// delta add with wrap and repeat checks, end-of-stream status. Uses plddv_pkg.
module plddv_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  plddv_pkg::in_item_t item,
  output logic                res_vld,
  output plddv_pkg::out_item_t res
);
  import plddv_pkg::*;

  logic                   in_block_r, in_block_nxt;
  logic [7:0]             ids_left_r, ids_left_nxt;
  logic                   in_varint_r, in_varint_nxt;
  logic [63:0]            delta_r, delta_nxt;
  logic [6:0]             shift_r, shift_nxt;
  logic [63:0]            prev_r, prev_nxt;
  logic                   seen_r, seen_nxt;
  logic [1:0]             err_r, err_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic [6:0]  payload;
  logic [63:0] accum;
  logic [64:0] sum;
  logic [63:0] cnt64;
  logic [63:0] id_val;
  logic [1:0]  st;

  always_comb begin
    payload = item.data_byte[6:0];
    accum   = delta_r | (64'(payload) << shift_r[5:0]);
    sum     = {1'b0, prev_r} + {1'b0, accum};
    id_val  = seen_r ? sum[63:0] : accum;
    cnt64   = 64'(cnt_r);

    in_block_nxt  = in_block_r;
    ids_left_nxt  = ids_left_r;
    in_varint_nxt = in_varint_r;
    delta_nxt     = delta_r;
    shift_nxt     = shift_r;
    prev_nxt      = prev_r;
    seen_nxt      = seen_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    res_vld       = 1'b0;
    res           = '0;
    st            = err_r;

    if (go) begin
      if (item.command == CMD_EOS) begin
        if (err_r == ST_OK && (in_block_r || in_varint_r)) begin
          st = ST_TRUNC;
        end
        res_vld            = 1'b1;
        res.result_kind    = KIND_STATUS;
        res.status         = st;
        if (st == ST_OK) begin
          res.consumed_bytes = (|cnt64[63:32]) ? 32'hFFFF_FFFF : cnt64[31:0];
        end
        in_block_nxt  = 1'b0;
        ids_left_nxt  = '0;
        in_varint_nxt = 1'b0;
        delta_nxt     = '0;
        shift_nxt     = '0;
        prev_nxt      = '0;
        seen_nxt      = 1'b0;
        err_nxt       = ST_OK;
        cnt_nxt       = '0;
      end else if (err_r == ST_OK) begin
        if (!(&cnt_r)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (!in_block_r) begin
          if (item.data_byte == 8'd0) begin
            err_nxt = ST_CORRUPT;
          end else begin
            in_block_nxt  = 1'b1;
            ids_left_nxt  = item.data_byte;
            in_varint_nxt = 1'b0;
            delta_nxt     = '0;
            shift_nxt     = '0;
          end
        end else if (shift_r[6] || (shift_r == SHIFT_LAST && payload > 7'd1)) begin
          err_nxt = ST_CORRUPT;
        end else if (item.data_byte[7]) begin
          delta_nxt     = accum;
          in_varint_nxt = 1'b1;
          shift_nxt     = shift_r + SHIFT_STEP;
        end else if (seen_r && (accum == 64'd0 || sum[64])) begin
          delta_nxt = accum;
          err_nxt   = ST_CORRUPT;
        end else begin
          prev_nxt      = id_val;
          seen_nxt      = 1'b1;
          in_varint_nxt = 1'b0;
          delta_nxt     = '0;
          shift_nxt     = '0;
          ids_left_nxt  = ids_left_r - 8'd1;
          if (ids_left_r == 8'd1) begin
            in_block_nxt = 1'b0;
          end
          res_vld         = 1'b1;
          res.result_kind = KIND_ID;
          res.doc_id      = id_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r  <= 1'b0;
      ids_left_r  <= '0;
      in_varint_r <= 1'b0;
      delta_r     <= '0;
      shift_r     <= '0;
      prev_r      <= '0;
      seen_r      <= 1'b0;
      err_r       <= ST_OK;
      cnt_r       <= '0;
    end else begin
      in_block_r  <= in_block_nxt;
      ids_left_r  <= ids_left_nxt;
      in_varint_r <= in_varint_nxt;
      delta_r     <= delta_nxt;
      shift_r     <= shift_nxt;
      prev_r      <= prev_nxt;
      seen_r      <= seen_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

// ===== design/plddv_out_stage.sv =====
// Result register of the decoder: holds one result until downstream takes it.
// Depends on plddv_pkg.
module plddv_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  plddv_pkg::out_item_t res,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output plddv_pkg::out_item_t out_data
);
  import plddv_pkg::*;

  logic      vld_r;
  out_item_t data_r;

  assign can_take  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (can_take) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_take) begin
      data_r <= res;
    end
  end

endmodule

// ===== design/posting_list_delta_varint_decoder.sv =====
// Posting-list delta varint decoder, top level. Depends on plddv_pkg and the
// plddv_in_stage, plddv_core and plddv_out_stage modules.
// Requests wait in the input register; the core decodes combinationally into the result register.
// Throughput: 1 byte per cycle; input stalls only while both stages are full and out_ready is low.
// Reset: synchronous active-low rst_n clears all decode state and both stages.
module posting_list_delta_varint_decoder #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  plddv_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output plddv_pkg::out_item_t out_data
);
  import plddv_pkg::*;

  logic      stg_vld;
  in_item_t  stg_item;
  logic      can_take;
  logic      take;
  logic      res_vld;
  out_item_t res;

  assign take = stg_vld && can_take;

  plddv_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .vld      (stg_vld),
    .item     (stg_item)
  );

  plddv_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (take),
    .item    (stg_item),
    .res_vld (res_vld),
    .res     (res)
  );

  plddv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_status_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_STATUS |-> out_data.doc_id == 64'd0)
    else $error("status result carries an id");

  a_id_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_ID
      |-> out_data.status == ST_OK && out_data.consumed_bytes == 32'd0)
    else $error("id result carries status fields");

  a_err_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.consumed_bytes == 32'd0)
    else $error("byte count reported on failed stream");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> stg_vld && out_valid && !out_ready)
    else $error("input stalled without output backpressure");

endmodule

// ===== tb/plddv_checker.sv =====
// Checker for the posting-list delta varint decoder: watches both channels,
// predicts the id and status results from the accepted requests and compares.
// Depends on plddv_pkg.
module plddv_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  plddv_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  plddv_pkg::out_item_t out_data,
  output int unsigned          mismatch_count,
  output int unsigned          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import plddv_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  logic        blk_open;
  logic [7:0]  deltas_due;
  logic        varint_open;
  logic [63:0] accum;
  logic [6:0]  shift_pos;
  logic [63:0] last_id;
  logic        have_id;
  logic [1:0]  fault;
  logic [31:0] bytes_seen;

  out_item_t   expected_q [$];
  int unsigned fails = 0;

  assign mismatch_count = fails;

  function automatic void clear_decode();
    blk_open    = 1'b0;
    deltas_due  = '0;
    varint_open = 1'b0;
    accum       = '0;
    shift_pos   = '0;
    last_id     = '0;
    have_id     = 1'b0;
    fault       = ST_OK;
    bytes_seen  = '0;
  endfunction

  // Returns 1 when the request produces a result, written to res.
  function automatic bit decode_request(input in_item_t req, output out_item_t res);
    logic [63:0] payload;
    logic [63:0] sum;
    res = '0;
    if (req.command == CMD_EOS) begin
      res.result_kind = KIND_STATUS;
      res.status = fault;
      if (fault == ST_OK && (blk_open || varint_open)) res.status = ST_TRUNC;
      if (res.status == ST_OK) res.consumed_bytes = bytes_seen;
      clear_decode();
      return 1'b1;
    end
    if (fault != ST_OK) return 1'b0;
    if (bytes_seen != '1) bytes_seen++;
    if (!blk_open) begin
      if (req.data_byte == 8'h00) begin
        fault = ST_CORRUPT;
        return 1'b0;
      end
      blk_open    = 1'b1;
      deltas_due  = req.data_byte;
      varint_open = 1'b0;
      accum       = '0;
      shift_pos   = '0;
      return 1'b0;
    end
    payload = 64'(req.data_byte[6:0]);
    if (shift_pos > SHIFT_LAST || (shift_pos == SHIFT_LAST && payload > 64'd1)) begin
      fault = ST_CORRUPT;
      return 1'b0;
    end
    accum |= payload << shift_pos;
    if (req.data_byte[7]) begin
      varint_open = 1'b1;
      shift_pos += SHIFT_STEP;
      return 1'b0;
    end
    if (have_id) begin
      if (accum == '0) begin
        fault = ST_CORRUPT;
        return 1'b0;
      end
      sum = last_id + accum;
      if (sum < last_id) begin
        fault = ST_CORRUPT;
        return 1'b0;
      end
    end else begin
      sum = accum;
    end
    last_id     = sum;
    have_id     = 1'b1;
    varint_open = 1'b0;
    accum       = '0;
    shift_pos   = '0;
    deltas_due--;
    if (deltas_due == '0) blk_open = 1'b0;
    res.result_kind = KIND_ID;
    res.doc_id = sum;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_decode();
      expected_q.delete();
      awaiting <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: unexpected result kind=%0d id=%h status=%0d bytes=%0d", $realtime,
                     out_data.result_kind, out_data.doc_id, out_data.status,
                     out_data.consumed_bytes);
        end else begin
          want = expected_q.pop_front();
          if (want.result_kind !== out_data.result_kind || want.doc_id !== out_data.doc_id ||
              want.status !== out_data.status ||
              want.consumed_bytes !== out_data.consumed_bytes) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display(
                "%0t: mismatch exp kind=%0d id=%h st=%0d n=%0d, got kind=%0d id=%h st=%0d n=%0d",
                $realtime, want.result_kind, want.doc_id, want.status,
                want.consumed_bytes, out_data.result_kind, out_data.doc_id,
                out_data.status, out_data.consumed_bytes);
          end
        end
      end
      if (in_valid && in_ready && decode_request(in_data, want))
        expected_q.insert(expected_q.size(), want);
      awaiting <= expected_q.size();
    end
  end

endmodule

// ===== tb/tb_posting_list_delta_varint_decoder.sv =====
// Top of the posting-list delta varint decoder testbench: clock, reset, byte
// stream stimulus with random idling and back-pressure, and the verdict.
// Depends on plddv_pkg, posting_list_delta_varint_decoder and plddv_checker.
module tb_posting_list_delta_varint_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import plddv_pkg::*;

  localparam int TOTAL_REQS   = 1750;
  localparam int HOLD_CYCLES  = 64;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    FLAW_NONE, FLAW_CUT, FLAW_ZERO_COUNT, FLAW_TENTH_BYTE, FLAW_ELEVEN_BYTES,
    FLAW_ZERO_DELTA, FLAW_WRAP, FLAW_NOISE
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  int unsigned mismatches;
  int unsigned pending;

  int          in_idle_pct = 8;
  int          out_idle_pct = 60;
  int          hold_asked = 0;
  int          hold_done = 0;
  int          live_reqs = 0;
  logic [7:0]  stream_bytes [$];
  int          useful_len;

  // empty stream, zero count, largest id, first id zero then zero delta,
  // stream ending inside a block
  logic [8:0] opening_reqs [24] = '{
    {CMD_EOS, 8'h00},
    {CMD_DATA, 8'h00}, {CMD_DATA, 8'h7F}, {CMD_EOS, 8'hFF},
    {CMD_DATA, 8'h01}, {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF},
    {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF},
    {CMD_DATA, 8'hFF}, {CMD_DATA, 8'hFF}, {CMD_DATA, 8'h01}, {CMD_EOS, 8'h5A},
    {CMD_DATA, 8'h02}, {CMD_DATA, 8'h00}, {CMD_DATA, 8'h00}, {CMD_EOS, 8'hA5},
    {CMD_DATA, 8'h02}, {CMD_DATA, 8'h81}, {CMD_DATA, 8'h01}, {CMD_EOS, 8'h00}
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  posting_list_delta_varint_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  plddv_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatches),
    .awaiting       (pending)
  );

  task automatic send_req(input logic cmd, input logic [7:0] b, input bit counted);
    int gap;
    in_item_t req;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.command   = cmd;
    req.data_byte = b;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) live_reqs++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  function automatic logic [63:0] rand_bits(input int max_bits);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v >> (64 - int'($urandom_range(max_bits, 1)));
  endfunction

  function automatic void push_varint(input logic [63:0] v, input int pad);
    int groups;
    int total;
    int i;
    logic [7:0] b;
    groups = 1;
    while (groups < 10 && (v >> (7 * groups)) != '0) groups++;
    total = (groups + pad > 10) ? 10 : groups + pad;
    for (i = 0; i < total; i++) begin
      b = 8'((v >> (7 * i)) & 64'h7F);
      if (i < total - 1) b[7] = 1'b1;
      append_byte(b);
    end
  endfunction

  function automatic int rand_pad();
    return ($urandom_range(9) == 0) ? int'($urandom_range(2, 1)) : 0;
  endfunction

  function automatic flaw_t pick_flaw();
    int r;
    r = $urandom_range(99);
    if (r < 65) return FLAW_NONE;
    if (r < 75) return FLAW_CUT;
    if (r < 78) return FLAW_ZERO_COUNT;
    if (r < 82) return FLAW_TENTH_BYTE;
    if (r < 85) return FLAW_ELEVEN_BYTES;
    if (r < 89) return FLAW_ZERO_DELTA;
    if (r < 94) return FLAW_WRAP;
    return FLAW_NOISE;
  endfunction

  // Fills stream_bytes with one stream; a flaw other than a cut or noise lands in the last block and
  // is followed by up to four junk bytes that the block should ignore; a cut truncates the stream.
  function automatic void build_stream(input flaw_t flaw);
    logic [63:0] prev;
    logic [63:0] delta;
    logic [63:0] r;
    int blocks;
    int blk;
    int cnt;
    int bad_at;
    int k;
    bit first;
    bit needs_id;
    stream_bytes.delete();
    useful_len = -1;
    prev  = '0;
    first = 1'b1;
    needs_id = (flaw == FLAW_ZERO_DELTA || flaw == FLAW_WRAP);
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(20, 1)) append_byte(8'($urandom));
      useful_len = stream_bytes.size();
      return;
    end
    blocks = $urandom_range(3, 1);
    for (blk = 0; blk < blocks; blk++) begin
      if (blk == blocks - 1 && flaw == FLAW_ZERO_COUNT) begin
        append_byte(8'h00);
        useful_len = stream_bytes.size();
        break;
      end
      cnt = ($urandom_range(199) == 0) ? int'($urandom_range(254, 200))
                                       : int'($urandom_range(6, 1));
      bad_at = -1;
      if (blk == blocks - 1 && flaw inside {FLAW_TENTH_BYTE, FLAW_ELEVEN_BYTES,
                                            FLAW_ZERO_DELTA, FLAW_WRAP}) begin
        if (first && needs_id && cnt < 2) cnt = 2;
        bad_at = $urandom_range(cnt - 1, (first && needs_id) ? 1 : 0);
      end
      append_byte(8'(cnt));
      for (k = 0; k < cnt; k++) begin
        if (k == bad_at) begin
          case (flaw)
            FLAW_TENTH_BYTE: begin
              repeat (9) append_byte({1'b1, 7'($urandom)});
              append_byte({1'($urandom), 7'($urandom_range(127, 2))});
            end
            FLAW_ELEVEN_BYTES: begin
              repeat (9) append_byte({1'b1, 7'($urandom)});
              append_byte({1'b1, 6'd0, 1'($urandom)});
              append_byte(8'($urandom));
            end
            FLAW_ZERO_DELTA: push_varint('0, rand_pad());
            default: begin
              r = rand_bits(64);
              if (prev != '0) r = r % prev;
              push_varint(r - prev, rand_pad());
            end
          endcase
          useful_len = stream_bytes.size();
          break;
        end
        if (first) begin
          delta = rand_bits(($urandom_range(9) < 7) ? 20 : 64);
        end else begin
          delta = rand_bits(($urandom_range(9) < 8) ? 14 : 62);
          if (delta == '0) delta = 64'd1;
        end
        push_varint(delta, rand_pad());
        prev  = first ? delta : prev + delta;
        first = 1'b0;
      end
      if (bad_at >= 0) break;
    end
    if (useful_len >= 0) begin
      repeat ($urandom_range(4, 0)) append_byte(8'($urandom));
    end else begin
      if (flaw == FLAW_CUT && stream_bytes.size() > 1)
        stream_bytes = stream_bytes[0:$urandom_range(stream_bytes.size() - 1, 1) - 1];
      useful_len = stream_bytes.size();
    end
  endfunction

  task automatic run_stream(input flaw_t flaw);
    int i;
    build_stream(flaw);
    for (i = 0; i < stream_bytes.size(); i++)
      send_req(CMD_DATA, stream_bytes[i], i < useful_len);
    send_req(CMD_EOS, 8'($urandom), 1'b1);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_reqs[i]) send_req(opening_reqs[i][8], opening_reqs[i][7:0], 1'b1);
    while (live_reqs < 600) run_stream(pick_flaw());
    wait_drained();

    in_idle_pct  = 60;
    out_idle_pct = 8;
    while (live_reqs < 1150) run_stream(pick_flaw());
    wait_drained();

    // receiver holds off while a full 255-id block streams in
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_asked++;
    send_req(CMD_DATA, 8'hFF, 1'b1);
    send_req(CMD_DATA, 8'($urandom_range(127, 0)), 1'b1);
    repeat (254) send_req(CMD_DATA, 8'($urandom_range(127, 1)), 1'b1);
    send_req(CMD_EOS, 8'($urandom), 1'b1);
    while (live_reqs < TOTAL_REQS) run_stream(pick_flaw());
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
